// ----- rtl/core/tle_pkg.sv -----
// Shared types and constants for the terminal line editor with history.
// Depends on nothing; used by the top level and the testbench.
`default_nettype none

package tle_pkg;

  localparam int unsigned LINE_MAX_DEF      = 32;
  localparam int unsigned HISTORY_DEPTH_DEF = 32;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned LEN_W             = 6;
  localparam int unsigned KIND_W            = 2;

  localparam logic [7:0] CH_ETX    = 8'd3;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'd127;

  typedef enum logic [1:0] {
    KIND_ECHO,
    KIND_ERASE,
    KIND_LINE,
    KIND_END
  } kind_e;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_SEEN,
    ESC_CSI
  } esc_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ECHO,
    S_ERASE,
    S_RLEN_RD,
    S_RLEN,
    S_RCP_RD,
    S_RCP,
    S_DLV_RD,
    S_DLV,
    S_END,
    S_CMP_LEN_RD,
    S_CMP_LEN,
    S_CMP_RD,
    S_CMP,
    S_ST_RD,
    S_ST,
    S_ST_LEN
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/core/terminal_line_editor_with_history_unit.sv -----
// Top level of the terminal line editor with a ring of past lines.
// Depends on tle_pkg and tle_ram.
//
// Usage: one received byte enters per s_axis transfer (tdata = rx_byte).
// Results leave on m_axis: tuser = kind, tdata = data and line_length,
// tlast marks the final result caused by the byte. A byte that causes no
// result gives no transfer.
// A printable byte is echoed, and a backspace answered with an erase, the
// cycle after its transfer. Enter emits the echo, then each delivered byte
// and the end marker; Control-C emits ^C and a line feed, then an end marker
// of length zero. Storing a line compares it with the newest line and,
// unless equal, copies it. A recall emits one erase per character, then the
// recalled bytes. Each RAM has a single read port with registered read data:
// each stored byte is read in one state and used in the next. The longest
// case is Enter on a full line whose compare with the newest line fails at
// the last byte. The editor takes one byte at a time; s_axis_tready is high
// only while idle and the output register can take a result.
// Reset clears the counters, the escape state and the output valid flag; the
// RAMs are not cleared. When the receiver stalls the output register holds
// its result and the editor waits.
`default_nettype none

module terminal_line_editor_with_history_unit #(
  parameter int unsigned LINE_MAX      = tle_pkg::LINE_MAX_DEF,
  parameter int unsigned HISTORY_DEPTH = tle_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // [7:0] data, [13:8] line_length, [15:14] zero
  output logic [1:0]       m_axis_tuser_o,  // [1:0] kind
  output logic             m_axis_tlast_o
);

  import tle_pkg::*;

  localparam int unsigned IW = $clog2(LINE_MAX);
  localparam int unsigned CW = $clog2(LINE_MAX + 1);
  localparam int unsigned SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned HW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned TD = HISTORY_DEPTH * LINE_MAX;
  localparam int unsigned AW = $clog2(TD);

  state_e state_q, state_d;
  esc_e   esc_q, esc_d;
  logic [CW-1:0] lc_q, lc_d;
  logic [HW-1:0] hcnt_q, hcnt_d;
  logic [SW-1:0] wslot_q, wslot_d;
  logic [HW-1:0] recall_q, recall_d;
  logic [SW-1:0] rslot_q, rslot_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] rlen_q, rlen_d;
  logic          k0_q, k0_d;
  logic [1:0]    echo_q, echo_d;

  logic          ov_q;
  kind_e         okind_q;
  logic [7:0]    odata_q;
  logic [LEN_W-1:0] olen_q;
  logic          olast_q;

  logic          out_free, in_fire, fire;
  logic          emit, emit_last;
  kind_e         emit_kind;
  logic [7:0]    emit_data;
  logic [LEN_W-1:0] emit_len;

  logic          lb_we;
  logic [IW-1:0] lb_waddr;
  logic [7:0]    lb_wdata, lb_rdata;
  logic          hist_we;
  logic [AW-1:0] hist_waddr, hist_raddr;
  logic [7:0]    hist_rdata;
  logic          len_we;
  logic [CW-1:0] len_rdata;

  logic [7:0]    c;
  logic [HW:0]   k_up;
  logic          up_ok;
  logic [HW-1:0] k_dn;
  logic          printable;
  logic          idx_at_end;

  function automatic logic [SW-1:0] past_slot(logic [SW-1:0] ws, logic [HW-1:0] k);
    logic [SW:0] tmp;
    tmp = {1'b0, ws} + (SW+1)'(HISTORY_DEPTH) - (SW+1)'(k);
    if (tmp >= (SW+1)'(HISTORY_DEPTH)) begin
      tmp = tmp - (SW+1)'(HISTORY_DEPTH);
    end
    return tmp[SW-1:0];
  endfunction

  function automatic logic [AW-1:0] haddr(logic [SW-1:0] slot, logic [IW-1:0] i);
    return AW'(slot) * AW'(LINE_MAX) + AW'(i);
  endfunction

  assign out_free   = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign fire       = emit && out_free;
  assign c          = s_axis_tdata_i;
  assign k_up       = {1'b0, recall_q} + (HW+1)'(1);
  assign up_ok      = k_up <= {1'b0, hcnt_q};
  assign k_dn       = (recall_q == '0) ? '0 : recall_q - HW'(1);
  assign printable  = (c >= CH_SPACE) && (c < CH_DEL);
  assign idx_at_end = (CW'(idx_q) == lc_q - CW'(1));
  assign hist_raddr = haddr(rslot_q, idx_q);

  tle_ram #(.Width(8), .Depth(LINE_MAX)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (lb_waddr),
    .wdata_i (lb_wdata),
    .raddr_i (idx_q),
    .rdata_o (lb_rdata)
  );

  tle_ram #(.Width(8), .Depth(TD)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (lb_rdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  tle_ram #(.Width(CW), .Depth(HISTORY_DEPTH), .AddrW(SW)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (wslot_q),
    .wdata_i (lc_q),
    .raddr_i (rslot_q),
    .rdata_o (len_rdata)
  );

  always_comb begin
    state_d  = state_q;
    esc_d    = esc_q;
    lc_d     = lc_q;
    hcnt_d   = hcnt_q;
    wslot_d  = wslot_q;
    recall_d = recall_q;
    rslot_d  = rslot_q;
    idx_d    = idx_q;
    rlen_d   = rlen_q;
    k0_d     = k0_q;
    echo_d   = echo_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (esc_q)
            ESC_SEEN: begin
              esc_d = (c == CH_LBRACK || c == CH_O) ? ESC_CSI : ESC_IDLE;
            end
            ESC_CSI: begin
              esc_d = ESC_IDLE;
              if (c == CH_A && up_ok) begin
                recall_d = k_up[HW-1:0];
                rslot_d  = past_slot(wslot_q, k_up[HW-1:0]);
                k0_d     = 1'b0;
                state_d  = S_ERASE;
              end else if (c == CH_B) begin
                recall_d = k_dn;
                rslot_d  = past_slot(wslot_q, k_dn);
                k0_d     = (k_dn == '0);
                state_d  = S_ERASE;
              end
            end
            ESC_IDLE: begin
              if (c == CH_ESC) begin
                esc_d = ESC_SEEN;
              end else if (c == CH_LF || c == CH_CR) begin
                echo_d  = 2'd2;
                state_d = S_ECHO;
              end else if (c == CH_ETX) begin
                echo_d   = 2'd0;
                lc_d     = '0;
                recall_d = '0;
                state_d  = S_ECHO;
              end else if (c == CH_BS || c == CH_DEL) begin
                if (lc_q != '0) begin
                  lc_d = lc_q - CW'(1);
                end
              end else if (printable && lc_q < CW'(LINE_MAX)) begin
                lc_d = lc_q + CW'(1);
              end
            end
            default: esc_d = ESC_IDLE;
          endcase
        end
      end
      S_ECHO: begin
        if (fire) begin
          if (echo_q == 2'd2) begin
            idx_d   = '0;
            state_d = (lc_q == '0) ? S_END : S_DLV_RD;
          end else begin
            echo_d = echo_q + 2'd1;
          end
        end
      end
      S_ERASE: begin
        if (lc_q == '0) begin
          state_d = k0_q ? S_IDLE : S_RLEN_RD;
        end else if (fire) begin
          lc_d = lc_q - CW'(1);
        end
      end
      S_RLEN_RD: state_d = S_RLEN;
      S_RLEN: begin
        rlen_d  = len_rdata;
        idx_d   = '0;
        state_d = S_RCP_RD;
      end
      S_RCP_RD: state_d = S_RCP;
      S_RCP: begin
        if (fire) begin
          lc_d = CW'(idx_q) + CW'(1);
          if (CW'(idx_q) == rlen_q - CW'(1)) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = S_RCP_RD;
          end
        end
      end
      S_DLV_RD: state_d = S_DLV;
      S_DLV: begin
        if (fire) begin
          if (idx_at_end) begin
            state_d = S_END;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = S_DLV_RD;
          end
        end
      end
      S_END: begin
        if (fire) begin
          idx_d    = '0;
          recall_d = '0;
          if (lc_q == '0) begin
            state_d = S_IDLE;
          end else if (hcnt_q == '0) begin
            state_d = S_ST_RD;
          end else begin
            rslot_d = past_slot(wslot_q, HW'(1));
            state_d = S_CMP_LEN_RD;
          end
        end
      end
      S_CMP_LEN_RD: state_d = S_CMP_LEN;
      S_CMP_LEN: state_d = (len_rdata != lc_q) ? S_ST_RD : S_CMP_RD;
      S_CMP_RD: state_d = S_CMP;
      S_CMP: begin
        if (hist_rdata != lb_rdata) begin
          idx_d   = '0;
          state_d = S_ST_RD;
        end else if (idx_at_end) begin
          lc_d    = '0;
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = S_CMP_RD;
        end
      end
      S_ST_RD: state_d = S_ST;
      S_ST: begin
        if (idx_at_end) begin
          state_d = S_ST_LEN;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = S_ST_RD;
        end
      end
      S_ST_LEN: begin
        wslot_d = (wslot_q == SW'(HISTORY_DEPTH - 1)) ? '0 : wslot_q + SW'(1);
        if (hcnt_q < HW'(HISTORY_DEPTH)) begin
          hcnt_d = hcnt_q + HW'(1);
        end
        lc_d    = '0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    emit       = 1'b0;
    emit_kind  = KIND_ECHO;
    emit_data  = '0;
    emit_len   = '0;
    emit_last  = 1'b0;
    lb_we      = 1'b0;
    lb_waddr   = idx_q;
    lb_wdata   = c;
    hist_we    = 1'b0;
    hist_waddr = haddr(wslot_q, idx_q);
    len_we     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && esc_q == ESC_IDLE) begin
          if (c == CH_BS || c == CH_DEL) begin
            emit      = (lc_q != '0);
            emit_kind = KIND_ERASE;
            emit_last = 1'b1;
          end else if (printable && lc_q < CW'(LINE_MAX)) begin
            emit      = 1'b1;
            emit_data = c;
            emit_last = 1'b1;
            lb_we     = 1'b1;
            lb_waddr  = lc_q[IW-1:0];
          end
        end
      end
      S_ECHO: begin
        emit = 1'b1;
        case (echo_q)
          2'd0:    emit_data = CH_CARET;
          2'd1:    emit_data = CH_C;
          default: emit_data = CH_LF;
        endcase
      end
      S_ERASE: begin
        emit      = (lc_q != '0);
        emit_kind = KIND_ERASE;
        emit_last = k0_q && (lc_q == CW'(1));
      end
      S_RCP: begin
        emit      = 1'b1;
        emit_data = hist_rdata;
        emit_last = (CW'(idx_q) == rlen_q - CW'(1));
        lb_we     = fire;
        lb_wdata  = hist_rdata;
      end
      S_DLV: begin
        emit      = 1'b1;
        emit_kind = KIND_LINE;
        emit_data = lb_rdata;
      end
      S_END: begin
        emit      = 1'b1;
        emit_kind = KIND_END;
        emit_len  = LEN_W'(lc_q);
        emit_last = 1'b1;
      end
      S_ST:     hist_we = 1'b1;
      S_ST_LEN: len_we  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      esc_q    <= ESC_IDLE;
      lc_q     <= '0;
      hcnt_q   <= '0;
      wslot_q  <= '0;
      recall_q <= '0;
      rslot_q  <= '0;
      idx_q    <= '0;
      rlen_q   <= '0;
      k0_q     <= 1'b0;
      echo_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      esc_q    <= esc_d;
      lc_q     <= lc_d;
      hcnt_q   <= hcnt_d;
      wslot_q  <= wslot_d;
      recall_q <= recall_d;
      rslot_q  <= rslot_d;
      idx_q    <= idx_d;
      rlen_q   <= rlen_d;
      k0_q     <= k0_d;
      echo_q   <= echo_d;
      if (fire) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      okind_q <= emit_kind;
      odata_q <= emit_data;
      olen_q  <= emit_len;
      olast_q <= emit_last;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {2'b00, olen_q, odata_q};
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tlast_o  = olast_q;

`ifndef SYNTHESIS
  a_lc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lc_q <= CW'(LINE_MAX))
    else $error("line count above line size");

  a_hcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q <= HW'(HISTORY_DEPTH))
    else $error("history count above depth");

  a_recall_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    recall_q <= hcnt_q)
    else $error("recall index beyond stored lines");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !m_axis_tready_i) |=> (ov_q && $stable(m_axis_tdata_o)
      && $stable(m_axis_tlast_o)))
    else $error("pending result overwritten");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (state_q == S_IDLE))
    else $error("input taken while busy");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/tle_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module tle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- verif/tb_terminal_line_editor_with_history_unit.sv -----
// Testbench for the terminal line editor with history: drives received bytes on the
// input stream and checks echo, erase, delivered-line and end transfers against a
// behavioral predictor. Depends on tle_pkg and the top level RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb_terminal_line_editor_with_history_unit;
  import tle_pkg::*;

  localparam int LMAX = 32;
  localparam int HDEPTH = 32;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [5:0] len;
    logic       last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'd0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;
  logic [1:0]  m_user;
  logic        m_last;

  terminal_line_editor_with_history_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // editor state mirror
  logic [7:0] ed_line [LMAX];
  int         ed_count;
  logic [7:0] ed_hist [HDEPTH][LMAX];
  int         ed_hlen [HDEPTH];
  int         ed_hcount;
  int         ed_wslot;
  int         ed_recall;
  esc_e       ed_esc;

  result_t    expected_results[$];
  logic [7:0] pending_bytes[$];
  int         new_results;
  int         errors = 0;
  int         send_idle = 6;
  int         recv_idle = 45;
  bit         hold_send = 1'b0;

  function automatic void push_result(kind_e k, logic [7:0] d, int n);
    result_t r;
    r.kind = k;
    r.data = (k == KIND_ECHO || k == KIND_LINE) ? d : 8'd0;
    r.len  = (k == KIND_END) ? n[5:0] : 6'd0;
    r.last = 1'b0;
    expected_results.push_back(r);
    new_results++;
  endfunction

  function automatic int slot_of(int k);
    return (ed_wslot + HDEPTH - (k % HDEPTH)) % HDEPTH;
  endfunction

  function automatic void store_finished_line();
    int s;
    bit same;
    if (ed_count == 0) return;
    if (ed_hcount > 0) begin
      s = slot_of(1);
      same = (ed_hlen[s] == ed_count);
      for (int i = 0; i < ed_count; i++)
        if (ed_hist[s][i] != ed_line[i]) same = 1'b0;
      if (same) return;
    end
    s = ed_wslot;
    for (int i = 0; i < ed_count; i++) ed_hist[s][i] = ed_line[i];
    ed_hlen[s] = ed_count;
    ed_wslot = (s + 1) % HDEPTH;
    if (ed_hcount < HDEPTH) ed_hcount++;
  endfunction

  function automatic void recall_entry(int k);
    int s;
    if (k > ed_hcount) return;
    for (int i = 0; i < ed_count; i++) push_result(KIND_ERASE, 8'd0, 0);
    ed_count = 0;
    ed_recall = k;
    if (k == 0) return;
    s = slot_of(k);
    ed_count = ed_hlen[s];
    for (int i = 0; i < ed_count; i++) begin
      ed_line[i] = ed_hist[s][i];
      push_result(KIND_ECHO, ed_line[i], 0);
    end
  endfunction

  function automatic void deliver_current();
    for (int i = 0; i < ed_count; i++) push_result(KIND_LINE, ed_line[i], 0);
    push_result(KIND_END, 8'd0, ed_count);
    store_finished_line();
    ed_count = 0;
    ed_recall = 0;
  endfunction

  function automatic void predict_byte(logic [7:0] c);
    new_results = 0;
    if (ed_esc == ESC_SEEN) begin
      ed_esc = (c == CH_LBRACK || c == CH_O) ? ESC_CSI : ESC_IDLE;
    end else if (ed_esc == ESC_CSI) begin
      ed_esc = ESC_IDLE;
      if (c == CH_A) recall_entry(ed_recall + 1);
      else if (c == CH_B) recall_entry(ed_recall > 0 ? ed_recall - 1 : 0);
    end else if (c == CH_ESC) begin
      ed_esc = ESC_SEEN;
    end else if (c == CH_LF || c == CH_CR) begin
      push_result(KIND_ECHO, CH_LF, 0);
      deliver_current();
    end else if (c == CH_ETX) begin
      push_result(KIND_ECHO, CH_CARET, 0);
      push_result(KIND_ECHO, CH_C, 0);
      push_result(KIND_ECHO, CH_LF, 0);
      ed_count = 0;
      ed_recall = 0;
      deliver_current();
    end else if (c == CH_BS || c == CH_DEL) begin
      if (ed_count > 0) begin
        ed_count--;
        push_result(KIND_ERASE, 8'd0, 0);
      end
    end else if (c >= CH_SPACE && c < CH_DEL && ed_count < LMAX) begin
      ed_line[ed_count] = c;
      ed_count++;
      push_result(KIND_ECHO, c, 0);
    end
    if (new_results > 0) expected_results[$].last = 1'b1;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (s_valid && s_ready) predict_byte(s_data);
    if (!s_valid || s_ready) begin
      if (pending_bytes.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
        s_valid <= 1'b1;
        s_data  <= pending_bytes.pop_front();
      end else begin
        s_valid <= 1'b0;
      end
    end
    m_ready <= ($urandom_range(99) >= recv_idle);
  end

  // monitor
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_valid && m_ready) begin
      got.kind = kind_e'(m_user);
      got.data = m_data[7:0];
      got.len  = m_data[13:8];
      got.last = m_last;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %p", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endtask

  task automatic add_arrow(bit up);
    pending_bytes.push_back(CH_ESC);
    pending_bytes.push_back($urandom_range(1) ? CH_LBRACK : CH_O);
    pending_bytes.push_back(up ? CH_A : CH_B);
  endtask

  task automatic add_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) pending_bytes.push_back(8'($urandom_range(126, 32)));
      else if (pick < 58) pending_bytes.push_back($urandom_range(1) ? CH_BS : CH_DEL);
      else if (pick < 66) pending_bytes.push_back($urandom_range(1) ? CH_CR : CH_LF);
      else if (pick < 80) add_arrow($urandom_range(2) != 0);
      else if (pick < 83) pending_bytes.push_back(CH_ETX);
      else if (pick < 88) begin
        pending_bytes.push_back(CH_ESC);
        pending_bytes.push_back(8'($urandom_range(255)));
        pending_bytes.push_back(8'($urandom_range(255)));
      end else if (pick < 92) add_text("ls -l\r");
      else pending_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || s_valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    ed_count = 0; ed_hcount = 0; ed_wslot = 0; ed_recall = 0; ed_esc = ESC_IDLE;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, edit keys, full line, recall edges, swallowed escapes
    pending_bytes.push_back(CH_BS);
    add_arrow(1'b1);
    add_text(" ~ab");
    pending_bytes.push_back(CH_DEL);
    pending_bytes.push_back(CH_CR);
    add_text("ab\n");
    pending_bytes.push_back(8'd255);
    pending_bytes.push_back(8'd0);
    pending_bytes.push_back(8'd128);
    for (int i = 0; i < 33; i++) pending_bytes.push_back(8'h30 + i[7:0]);
    pending_bytes.push_back(CH_LF);
    add_arrow(1'b1); add_arrow(1'b1); add_arrow(1'b1); add_arrow(1'b1);
    add_arrow(1'b0); add_arrow(1'b0); add_arrow(1'b0);
    pending_bytes.push_back(CH_ESC); pending_bytes.push_back(8'h58);
    pending_bytes.push_back(CH_ESC); pending_bytes.push_back(CH_LBRACK);
    pending_bytes.push_back(8'h43);
    add_text("xy");
    pending_bytes.push_back(CH_ETX);
    wait_drained();
    add_random(25);
    wait_drained();
    send_idle = 45; recv_idle = 6;
    add_random(20);
    while (pending_bytes.size() > 10) @(posedge clk_i);
    hold_send = 1'b1;
    while (s_valid || expected_results.size() > 0) @(posedge clk_i);
    hold_send = 1'b0;
    wait_drained();
    // fill the whole ring and wrap it
    for (int i = 0; i < 33; i++) begin
      pending_bytes.push_back(8'h61 + 8'(i % 26));
      pending_bytes.push_back(CH_CR);
    end
    for (int i = 0; i < 4; i++) add_arrow(1'b1);
    pending_bytes.push_back(CH_CR);
    wait_drained();
    send_idle = 0; recv_idle = 0;
    add_random(20);
    wait_drained();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
